// File: rtl/uv_sphere_vertex_generator_top_assert.svh
// Assertion macros for the UV sphere vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define UVS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication checked at every clock edge outside reset.
`define UVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

// File: rtl/uvs_pkg.sv
// Package: constants, types and helpers of the UV sphere vertex generator.
package uvs_pkg;
   localparam int MAX_DIVISIONS = 1024;
   localparam int CORDIC_STAGES = 16;
   localparam int CNT_W = 11;
   localparam int IDX_W = 11;
   localparam int PH_W = 32;
   localparam int CW = 34;
   localparam int ZW = 33;
   localparam int QW = 19;
   localparam int DIV_STAGES = QW;
   localparam int DIVD_W = IDX_W + QW - 1;
   localparam int POS_W = 17;
   localparam int UNIT_W = 16;
   localparam int TEX_W = 17;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);
   localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [PH_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic [15:0] RADIUS_RST = 16'd256;
   localparam logic [CNT_W-1:0] SECTOR_RST = 11'd36;
   localparam logic [CNT_W-1:0] STACK_RST = 11'd18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_SECTORS = 2'd1,
      CSR_STACKS = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic flip;
   } rot_type;

   function automatic logic [ZW-1:0] atan_turn(input int i);
      logic [31:0] v;
      case (i)
         0: v = 32'h20000000; 1: v = 32'h12E4051E; 2: v = 32'h09FB385B;
         3: v = 32'h051111D4; 4: v = 32'h028B0D43; 5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E; 7: v = 32'h00517C55; 8: v = 32'h0028BE53;
         9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
         15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
         18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
         21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return {1'b0, v};
   endfunction

   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
      if (c == '0) return CNT_W'(1);
      if (c > CNT_W'(MAX_DIVISIONS)) return CNT_W'(MAX_DIVISIONS);
      return c;
   endfunction
endpackage

// File: rtl/uvs_cordic_cell.sv
// One CORDIC rotation cell with its pipeline register.
module uvs_cordic_cell (
   input  logic              clock,
   input  int unsigned       stage,
   input  uvs_pkg::rot_type  rot_in,
   output uvs_pkg::rot_type  rot_out
);
   import uvs_pkg::*;
   rot_type rot_in_c;
   rot_type rot_ff;
   logic signed [CW-1:0] ys, xs;

   always_comb begin
      ys = rot_in.y >>> stage;
      xs = rot_in.x >>> stage;
      rot_in_c = rot_in;
      if (!rot_in.z[ZW-1]) begin
         rot_in_c.x = rot_in.x - ys;
         rot_in_c.y = rot_in.y + xs;
         rot_in_c.z = rot_in.z - atan_turn(int'(stage));
      end else begin
         rot_in_c.x = rot_in.x + ys;
         rot_in_c.y = rot_in.y - xs;
         rot_in_c.z = rot_in.z + atan_turn(int'(stage));
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in_c;
   end
   assign rot_out = rot_ff;
endmodule

// File: rtl/uvs_div_cell.sv
// One restoring-division cell: one quotient bit per cell for two dividends.
module uvs_div_cell (
   input  logic                         clock,
   input  logic [uvs_pkg::DIVD_W-1:0]   rem_a_in,
   input  logic [uvs_pkg::DIVD_W-1:0]   rem_b_in,
   input  logic [uvs_pkg::CNT_W-1:0]    den_a_in,
   input  logic [uvs_pkg::CNT_W-1:0]    den_b_in,
   input  int unsigned                  shift,
   output logic [uvs_pkg::DIVD_W-1:0]   rem_a_out,
   output logic [uvs_pkg::DIVD_W-1:0]   rem_b_out,
   output logic [uvs_pkg::CNT_W-1:0]    den_a_out,
   output logic [uvs_pkg::CNT_W-1:0]    den_b_out,
   output logic                         q_a,
   output logic                         q_b
);
   import uvs_pkg::*;
   localparam int WW = DIVD_W + QW;
   logic [WW-1:0] da, db;
   logic ga, gb;
   logic [DIVD_W-1:0] rem_a_in_c, rem_b_in_c;
   logic [DIVD_W-1:0] rem_a_ff, rem_b_ff;
   logic [CNT_W-1:0] den_a_ff, den_b_ff;
   logic q_a_ff, q_b_ff;

   always_comb begin
      da = WW'(den_a_in) << shift;
      db = WW'(den_b_in) << shift;
      ga = WW'(rem_a_in) >= da;
      gb = WW'(rem_b_in) >= db;
      rem_a_in_c = ga ? DIVD_W'(WW'(rem_a_in) - da) : rem_a_in;
      rem_b_in_c = gb ? DIVD_W'(WW'(rem_b_in) - db) : rem_b_in;
   end

   always_ff @(posedge clock) begin
      rem_a_ff <= rem_a_in_c;
      rem_b_ff <= rem_b_in_c;
      den_a_ff <= den_a_in;
      den_b_ff <= den_b_in;
      q_a_ff <= ga;
      q_b_ff <= gb;
   end
   assign rem_a_out = rem_a_ff;
   assign rem_b_out = rem_b_ff;
   assign den_a_out = den_a_ff;
   assign den_b_out = den_b_ff;
   assign q_a = q_a_ff;
   assign q_b = q_b_ff;
endmodule

// File: rtl/uv_sphere_vertex_generator_top.sv
// UV sphere vertex generator: a chain of divider cells, then two chains of CORDIC cells, then
// the scaling multipliers.
// Usage:
//   Write sphere_radius (index 0), sector_count (1), stack_count (2) through csr_we, csr_index
//   and csr_data while no item is in flight. Counts of zero act as one, above 1024 as 1024.
//   Pulse start with req_stack_index and req_sector_index; an item is taken when start is
//   high and busy is low. busy is always low: a new item may enter every cycle.
//   Each result appears on the rsp_ ports for one cycle with rsp_valid high.
// Pipeline: 19 divider cells, 14 remainder cells, 1 phase stage, 16 CORDIC cells and
//   3 multiply/round stages lie between the accepting edge and rsp_valid.
//   Throughput: one item per cycle.
//   The divider chains (one quotient bit per cell) set the bulk of the latency.
// Reset: synchronous, active high; clears the registers to 256, 36 and 18 and empties the
//   pipeline valid line. There is no clearing pass.
// The receiver cannot stall: results are presented once and must be taken.
module uv_sphere_vertex_generator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [uvs_pkg::IDX_W-1:0]      req_stack_index,
   input  logic [uvs_pkg::IDX_W-1:0]      req_sector_index,
   input  logic                           csr_we,
   input  logic [uvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uvs_pkg::CSR_W-1:0]      csr_data,
   output logic                           rsp_valid,
   output logic signed [uvs_pkg::POS_W-1:0]  rsp_pos_x,
   output logic signed [uvs_pkg::POS_W-1:0]  rsp_pos_y,
   output logic signed [uvs_pkg::POS_W-1:0]  rsp_pos_z,
   output logic signed [uvs_pkg::UNIT_W-1:0] rsp_normal_x,
   output logic signed [uvs_pkg::UNIT_W-1:0] rsp_normal_y,
   output logic signed [uvs_pkg::UNIT_W-1:0] rsp_normal_z,
   output logic [uvs_pkg::TEX_W-1:0]      rsp_tex_u,
   output logic [uvs_pkg::TEX_W-1:0]      rsp_tex_v,
   output logic signed [uvs_pkg::UNIT_W-1:0] rsp_tangent_x,
   output logic signed [uvs_pkg::UNIT_W-1:0] rsp_tangent_y
);
   import uvs_pkg::*;
`include "uv_sphere_vertex_generator_top_assert.svh"

   localparam int LW = 14;
   localparam int LAT = DIV_STAGES + LW + 1 + CORDIC_STAGES + 3;

   logic [15:0] radius_ff;
   logic [CNT_W-1:0] sectors_ff, stacks_ff;
   logic [LAT-1:0] vld_ff;
   logic [CNT_W-1:0] n_sect, n_stack;
   logic [IDX_W-1:0] s_cl, t_cl;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         sectors_ff <= SECTOR_RST;
         stacks_ff <= STACK_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_RADIUS: radius_ff <= csr_data;
            CSR_SECTORS: sectors_ff <= csr_data[CNT_W-1:0];
            CSR_STACKS: stacks_ff <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   assign n_sect = eff_count(sectors_ff);
   assign n_stack = eff_count(stacks_ff);
   assign s_cl = (req_stack_index > n_stack) ? n_stack : req_stack_index;
   assign t_cl = (req_sector_index > n_sect) ? n_sect : req_sector_index;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LAT-2:0], start & ~busy};
   end
   assign rsp_valid = vld_ff[LAT-1];

   // divider chain: 19-bit quotients of s*2^18/n and t*2^18/n
   logic [DIVD_W-1:0] ra [DIV_STAGES+1];
   logic [DIVD_W-1:0] rb [DIV_STAGES+1];
   logic [CNT_W-1:0] da [DIV_STAGES+1];
   logic [CNT_W-1:0] db [DIV_STAGES+1];
   logic [DIV_STAGES-1:0] qa_bits, qb_bits;
   logic [QW-1:0] qa_acc [DIV_STAGES+1];
   logic [QW-1:0] qb_acc [DIV_STAGES+1];

   assign ra[0] = {s_cl, {(QW-1){1'b0}}};
   assign rb[0] = {t_cl, {(QW-1){1'b0}}};
   assign da[0] = n_stack;
   assign db[0] = n_sect;
   assign qa_acc[0] = '0;
   assign qb_acc[0] = '0;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      uvs_div_cell u_cell (
         .clock(clock), .rem_a_in(ra[g]), .rem_b_in(rb[g]),
         .den_a_in(da[g]), .den_b_in(db[g]), .shift(DIV_STAGES - 1 - g),
         .rem_a_out(ra[g+1]), .rem_b_out(rb[g+1]),
         .den_a_out(da[g+1]), .den_b_out(db[g+1]),
         .q_a(qa_bits[g]), .q_b(qb_bits[g])
      );
      logic [QW-1:0] qa_ff, qb_ff;
      always_ff @(posedge clock) begin
         qa_ff <= qa_acc[g];
         qb_ff <= qb_acc[g];
      end
      assign qa_acc[g+1] = {qa_ff[QW-2:0], qa_bits[g]};
      assign qb_acc[g+1] = {qb_ff[QW-2:0], qb_bits[g]};
   end

   // remainder chain: i*2^32/n = q*2^14 + rem*2^14/n
   logic [DIVD_W-1:0] la [LW+1];
   logic [DIVD_W-1:0] lb [LW+1];
   logic [CNT_W-1:0] lda [LW+1];
   logic [CNT_W-1:0] ldb [LW+1];
   logic [LW-1:0] la_bits, lb_bits;
   logic [LW-1:0] la_acc [LW+1];
   logic [LW-1:0] lb_acc [LW+1];
   logic [QW-1:0] qs_d [LW+1];
   logic [QW-1:0] qt_d [LW+1];

   assign la[0] = {ra[DIV_STAGES][DIVD_W-LW-1:0], {LW{1'b0}}};
   assign lb[0] = {rb[DIV_STAGES][DIVD_W-LW-1:0], {LW{1'b0}}};
   assign lda[0] = da[DIV_STAGES];
   assign ldb[0] = db[DIV_STAGES];
   assign la_acc[0] = '0;
   assign lb_acc[0] = '0;
   assign qs_d[0] = qa_acc[DIV_STAGES];
   assign qt_d[0] = qb_acc[DIV_STAGES];

   for (genvar g = 0; g < LW; g++) begin : g_lo
      uvs_div_cell u_cell (
         .clock(clock), .rem_a_in(la[g]), .rem_b_in(lb[g]),
         .den_a_in(lda[g]), .den_b_in(ldb[g]), .shift(LW - 1 - g),
         .rem_a_out(la[g+1]), .rem_b_out(lb[g+1]),
         .den_a_out(lda[g+1]), .den_b_out(ldb[g+1]),
         .q_a(la_bits[g]), .q_b(lb_bits[g])
      );
      logic [LW-1:0] la_ff, lb_ff;
      logic [QW-1:0] qs_ff, qt_ff;
      always_ff @(posedge clock) begin
         la_ff <= la_acc[g];
         lb_ff <= lb_acc[g];
         qs_ff <= qs_d[g];
         qt_ff <= qt_d[g];
      end
      assign la_acc[g+1] = {la_ff[LW-2:0], la_bits[g]};
      assign lb_acc[g+1] = {lb_ff[LW-2:0], lb_bits[g]};
      assign qs_d[g+1] = qs_ff;
      assign qt_d[g+1] = qt_ff;
   end

   // phase stage
   logic [PH_W-1:0] ph_s_in, ph_t_in;
   logic [TEX_W-1:0] tu_in, tv_in;
   logic [QW-1:0] qs, qt;
   logic [PH_W:0] fq_s, fq_t;
   assign qs = qs_d[LW];
   assign qt = qt_d[LW];
   always_comb begin
      fq_s = {qs, la_acc[LW]};
      fq_t = {qt, lb_acc[LW]};
      ph_s_in = QUARTER_TURN - fq_s[PH_W:1];
      ph_t_in = fq_t[PH_W-1:0];
      tu_in = TEX_W'((qt[QW-1:1] + (QW-1)'(1)) >> 1);
      tv_in = TEX_W'((qs[QW-1:1] + (QW-1)'(1)) >> 1);
   end

   rot_type rs_in, rt_in;
   logic flip_s, flip_t;
   logic [PH_W-1:0] ph_s_f, ph_t_f;
   always_comb begin
      flip_s = ph_s_in[31] ^ ph_s_in[30];
      flip_t = ph_t_in[31] ^ ph_t_in[30];
      ph_s_f = flip_s ? ph_s_in ^ HALF_TURN : ph_s_in;
      ph_t_f = flip_t ? ph_t_in ^ HALF_TURN : ph_t_in;
      rs_in = '{x: GAIN_Q30, y: '0, z: ZW'($signed(ph_s_f)), flip: flip_s};
      rt_in = '{x: GAIN_Q30, y: '0, z: ZW'($signed(ph_t_f)), flip: flip_t};
   end

   rot_type rs [CORDIC_STAGES+1];
   rot_type rt [CORDIC_STAGES+1];
   logic [PH_W-1:0] sph_d [CORDIC_STAGES+1];
   logic [TEX_W-1:0] tu_d [CORDIC_STAGES+1];
   logic [TEX_W-1:0] tv_d [CORDIC_STAGES+1];
   always_ff @(posedge clock) begin
      rs[0] <= rs_in;
      rt[0] <= rt_in;
      sph_d[0] <= ph_s_in;
      tu_d[0] <= tu_in;
      tv_d[0] <= tv_in;
   end
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
      uvs_cordic_cell u_s (.clock(clock), .stage(g), .rot_in(rs[g]), .rot_out(rs[g+1]));
      uvs_cordic_cell u_t (.clock(clock), .stage(g), .rot_in(rt[g]), .rot_out(rt[g+1]));
      always_ff @(posedge clock) begin
         sph_d[g+1] <= sph_d[g];
         tu_d[g+1] <= tu_d[g];
         tv_d[g+1] <= tv_d[g];
      end
   end

   // multiply stages
   logic signed [CW-1:0] cs, ss, ct, st;
   always_comb begin
      cs = rs[CORDIC_STAGES].flip ? -rs[CORDIC_STAGES].x : rs[CORDIC_STAGES].x;
      ss = rs[CORDIC_STAGES].flip ? -rs[CORDIC_STAGES].y : rs[CORDIC_STAGES].y;
      ct = rt[CORDIC_STAGES].flip ? -rt[CORDIC_STAGES].x : rt[CORDIC_STAGES].x;
      st = rt[CORDIC_STAGES].flip ? -rt[CORDIC_STAGES].y : rt[CORDIC_STAGES].y;
   end

   localparam int PW = 70;
   logic signed [PW-1:0] ring_p_ff, pz_p_ff, nx_p_ff, ny_p_ff;
   logic signed [CW-1:0] ct1_ff, st1_ff, ss1_ff;
   logic signed [CW-1:0] ring_ff, ct2_ff, st2_ff;
   logic signed [PW-1:0] px_p, py_p;
   logic [PH_W-1:0] sph1_ff, sph2_ff;
   logic [TEX_W-1:0] tu1_ff, tu2_ff, tv1_ff, tv2_ff;
   logic signed [PW-1:0] pz2_ff, nx2_ff, ny2_ff;
   logic signed [CW-1:0] ss2_ff;
   logic signed [PW-1:0] ring_r;

   always_ff @(posedge clock) begin
      ring_p_ff <= PW'($signed({1'b0, radius_ff})) * PW'(cs);
      pz_p_ff <= PW'($signed({1'b0, radius_ff})) * PW'(ss);
      nx_p_ff <= PW'(cs) * PW'(ct);
      ny_p_ff <= PW'(cs) * PW'(st);
      ct1_ff <= ct; st1_ff <= st; ss1_ff <= ss;
      sph1_ff <= sph_d[CORDIC_STAGES];
      tu1_ff <= tu_d[CORDIC_STAGES]; tv1_ff <= tv_d[CORDIC_STAGES];
   end

   assign ring_r = (ring_p_ff + PW'(1 << 13)) >>> 14;
   always_ff @(posedge clock) begin
      ring_ff <= CW'(ring_r);
      ct2_ff <= ct1_ff; st2_ff <= st1_ff; ss2_ff <= ss1_ff;
      pz2_ff <= pz_p_ff; nx2_ff <= nx_p_ff; ny2_ff <= ny_p_ff;
      sph2_ff <= sph1_ff; tu2_ff <= tu1_ff; tv2_ff <= tv1_ff;
   end

   function automatic logic signed [POS_W-1:0] satp(input logic signed [PW-1:0] v);
      if (v > PW'(65535)) return POS_W'(65535);
      if (v < -PW'(65535)) return -POS_W'(65535);
      return POS_W'(v);
   endfunction
   function automatic logic signed [UNIT_W-1:0] satu(input logic signed [PW-1:0] v);
      if (v > PW'(16384)) return UNIT_W'(16384);
      if (v < -PW'(16384)) return -UNIT_W'(16384);
      return UNIT_W'(v);
   endfunction

   logic signed [PW-1:0] pxr, pyr, pzr, nxr, nyr, nzr, txr, tyr;
   logic signed [UNIT_W-1:0] tx_s, ty_s;
   logic neg;
   always_comb begin
      px_p = PW'(ring_ff) * PW'(ct2_ff);
      py_p = PW'(ring_ff) * PW'(st2_ff);
      pxr = (px_p + (PW'(1) <<< 45)) >>> 46;
      pyr = (py_p + (PW'(1) <<< 45)) >>> 46;
      pzr = (pz2_ff + (PW'(1) <<< 29)) >>> 30;
      nxr = (nx2_ff + (PW'(1) <<< 45)) >>> 46;
      nyr = (ny2_ff + (PW'(1) <<< 45)) >>> 46;
      nzr = (PW'(ss2_ff) + PW'(1 << 15)) >>> 16;
      txr = (-PW'(st2_ff) + PW'(1 << 15)) >>> 16;
      tyr = (PW'(ct2_ff) + PW'(1 << 15)) >>> 16;
      neg = sph2_ff[31];
      tx_s = satu(txr);
      ty_s = satu(tyr);
   end

   always_ff @(posedge clock) begin
      rsp_pos_x <= satp(pxr);
      rsp_pos_y <= satp(pyr);
      rsp_pos_z <= satp(pzr);
      rsp_normal_x <= satu(nxr);
      rsp_normal_y <= satu(nyr);
      rsp_normal_z <= satu(nzr);
      rsp_tex_u <= tu2_ff;
      rsp_tex_v <= tv2_ff;
      rsp_tangent_x <= neg ? -tx_s : tx_s;
      rsp_tangent_y <= neg ? -ty_s : ty_s;
   end

   `UVS_ASSERT_IMP(a_busy_low, clock, reset, 1'b1, !busy)
   `UVS_ASSERT_NEXT(a_enter, clock, reset, start, vld_ff[0])
   `UVS_ASSERT_IMP(a_tex_u_max, clock, reset, rsp_valid, rsp_tex_u <= TEX_W'(65536))
   `UVS_ASSERT_IMP(a_tex_v_max, clock, reset, rsp_valid, rsp_tex_v <= TEX_W'(65536))
endmodule

// File: dv/uv_sphere_vertex_generator_top_tb.sv
// Self-checking testbench for the UV sphere vertex generator: directed and random vertices.
module uv_sphere_vertex_generator_top_tb;
   import uvs_pkg::*;

   localparam int LATENCY = 53;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_SHOWN = 10;

   typedef struct {
      logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
      logic signed [UNIT_W-1:0] nrm_x, nrm_y, nrm_z;
      logic [TEX_W-1:0] u, v;
      logic signed [UNIT_W-1:0] tan_x, tan_y;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [IDX_W-1:0] req_stack_index = '0;
   logic [IDX_W-1:0] req_sector_index = '0;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;
   logic rsp_valid;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [UNIT_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [TEX_W-1:0] rsp_tex_u, rsp_tex_v;
   logic signed [UNIT_W-1:0] rsp_tangent_x, rsp_tangent_y;

   vertex_type pending_vertices[$];
   int mismatches = 0;
   int cycles = 0;
   bit allow_gaps = 1'b1;

   logic [15:0] radius_reg;
   logic [CNT_W-1:0] sectors_reg, stacks_reg;

   const longint unsigned ATAN_TURNS[16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

   uv_sphere_vertex_generator_top DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic longint clip(input longint val, input longint lim);
      if (val > lim) return lim;
      if (val < -lim) return -lim;
      return val;
   endfunction

   function automatic longint round_down(input longint val, input int sh);
      return (val + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint unsigned count_of(input logic [CNT_W-1:0] c);
      if (c == 0) return 1;
      if (c > MAX_DIVISIONS) return MAX_DIVISIONS;
      return c;
   endfunction

   // rotate gain vector by phase (2^-32 turn units); q2.30 outputs
   task automatic rotate(input logic [31:0] ph, output longint cosv, output longint sinv);
      longint x, y, z, nx;
      bit flip;
      flip = ((ph + QUARTER_TURN) & HALF_TURN) != 0;
      if (flip) ph = ph ^ HALF_TURN;
      z = ph[31] ? longint'({32'b0, ph}) - (longint'(1) <<< 32) : longint'({32'b0, ph});
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(ATAN_TURNS[i]);
         end
         x = nx;
      end
      cosv = flip ? -x : x;
      sinv = flip ? -y : y;
   endtask

   task automatic predict_vertex(input logic [IDX_W-1:0] si, input logic [IDX_W-1:0] ti,
                                 output vertex_type vx);
      longint unsigned n_st, n_se, s, t;
      logic [31:0] st_ph, se_ph;
      longint cs, ss, ct, sn, r, ring, sgn;
      n_st = count_of(stacks_reg);
      n_se = count_of(sectors_reg);
      s = (si > n_st) ? n_st : si;
      t = (ti > n_se) ? n_se : ti;
      st_ph = QUARTER_TURN - 32'((s << 31) / n_st);
      se_ph = 32'((t << 32) / n_se);
      rotate(st_ph, cs, ss);
      rotate(se_ph, ct, sn);
      r = radius_reg;
      ring = round_down(r * cs, 14);
      vx.pos_x = POS_W'(clip(round_down(ring * ct, 46), 65535));
      vx.pos_y = POS_W'(clip(round_down(ring * sn, 46), 65535));
      vx.pos_z = POS_W'(clip(round_down(r * ss, 30), 65535));
      vx.nrm_x = UNIT_W'(clip(round_down(cs * ct, 46), 16384));
      vx.nrm_y = UNIT_W'(clip(round_down(cs * sn, 46), 16384));
      vx.nrm_z = UNIT_W'(clip(round_down(ss, 16), 16384));
      vx.u = TEX_W'((t * 131072 + n_se) / (2 * n_se));
      vx.v = TEX_W'((s * 131072 + n_st) / (2 * n_st));
      sgn = st_ph[31] ? -1 : 1;
      vx.tan_x = UNIT_W'(sgn * clip(round_down(-sn, 16), 16384));
      vx.tan_y = UNIT_W'(sgn * clip(round_down(ct, 16), 16384));
   endtask

   task automatic report(input string field, input longint want, input longint got);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display("mismatch %s: expected %0d, got %0d", field, want, got);
   endtask

   always @(posedge clock) begin
      vertex_type w;
      if (!reset && rsp_valid) begin
         if (pending_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) $display("unexpected item on rsp");
         end else begin
            w = pending_vertices.pop_front();
            if (rsp_pos_x !== w.pos_x) report("pos_x", w.pos_x, rsp_pos_x);
            if (rsp_pos_y !== w.pos_y) report("pos_y", w.pos_y, rsp_pos_y);
            if (rsp_pos_z !== w.pos_z) report("pos_z", w.pos_z, rsp_pos_z);
            if (rsp_normal_x !== w.nrm_x) report("normal_x", w.nrm_x, rsp_normal_x);
            if (rsp_normal_y !== w.nrm_y) report("normal_y", w.nrm_y, rsp_normal_y);
            if (rsp_normal_z !== w.nrm_z) report("normal_z", w.nrm_z, rsp_normal_z);
            if (rsp_tex_u !== w.u) report("tex_u", w.u, rsp_tex_u);
            if (rsp_tex_v !== w.v) report("tex_v", w.v, rsp_tex_v);
            if (rsp_tangent_x !== w.tan_x) report("tangent_x", w.tan_x, rsp_tangent_x);
            if (rsp_tangent_y !== w.tan_y) report("tangent_y", w.tan_y, rsp_tangent_y);
         end
      end
   end

   task automatic send_vertex(input logic [IDX_W-1:0] si, input logic [IDX_W-1:0] ti);
      vertex_type vx;
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      start = 1'b1;
      req_stack_index = si;
      req_sector_index = ti;
      do @(posedge clock); while (busy);
      predict_vertex(si, ti, vx);
      pending_vertices = {pending_vertices, vx};
      @(negedge clock);
   endtask

   task automatic drain;
      start = 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_RADIUS: radius_reg = val;
         CSR_SECTORS: sectors_reg = val[CNT_W-1:0];
         CSR_STACKS: stacks_reg = val[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic setup(input logic [15:0] r, input logic [CSR_W-1:0] se,
                        input logic [CSR_W-1:0] st);
      drain();
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_SECTORS, se);
      write_reg(CSR_STACKS, st);
   endtask

   // default registers: poles, equator, seam, clamped indices
   task automatic test_reset_values;
      send_vertex(0, 0);
      send_vertex(18, 0);
      send_vertex(9, 0);
      send_vertex(9, 9);
      send_vertex(9, 36);
      send_vertex(13, 27);
      send_vertex(2047, 2047);
      send_vertex(19, 37);
   endtask

   task automatic test_extremes;
      setup(16'hFFFF, 1024, 1024);
      send_vertex(512, 0);
      send_vertex(0, 1023);
      send_vertex(1024, 1024);
      send_vertex(700, 333);
      setup(0, 0, 0);
      send_vertex(0, 0);
      send_vertex(1, 1);
      send_vertex(2047, 1024);
      setup(16'h0001, 16'hFFFF, 2047);
      send_vertex(1023, 511);
      send_vertex(512, 2047);
      setup(16'h8000, 1, 2);
      send_vertex(1, 0);
      send_vertex(2, 1);
      send_vertex(1, 2);
   endtask

   task automatic test_random;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: setup(256, 36, 18);
            1: setup(16'($urandom), 16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)));
            2: setup(16'hFFFF, 16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
            3: setup(16'($urandom), 16'($urandom), 16'($urandom));
            default: setup(16'($urandom_range(0, 1024)), 4, 4);
         endcase
         if (phase == 4) allow_gaps = 1'b0;
         for (int k = 0; k < 100; k++) begin
            if (phase == 2 && k == 50) drain();
            if ($urandom_range(0, 4) == 0)
               send_vertex(11'($urandom), 11'($urandom));
            else
               send_vertex(11'($urandom_range(0, count_of(stacks_reg))),
                           11'($urandom_range(0, count_of(sectors_reg))));
         end
      end
   endtask

   initial begin
      radius_reg = RADIUS_RST;
      sectors_reg = SECTOR_RST;
      stacks_reg = STACK_RST;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_extremes();
      test_random();
      drain();
      if (mismatches == 0 && pending_vertices.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
